[src/qtg_pkg.sv]
// qtg_pkg: shared types, constants and the saturation helper for the
// quintic trajectory generator; no dependencies
package qtg_pkg;

    // field widths
    localparam int POS_W = 32;
    localparam int DUR_W = 31;
    localparam int MAG_W = 33;

    // quotient bits per divider and multiplier stage count
    localparam int S_QBITS     = 31;
    localparam int V_QBITS     = 32;
    localparam int A1_QBITS    = 59;
    localparam int A2_QBITS    = 33;
    localparam int POLY_STAGES = 4;

    // input register, dividers, multiplier stages, output register
    localparam int LATENCY = 1 + S_QBITS + POLY_STAGES + V_QBITS + A1_QBITS + A2_QBITS + 1;

    typedef enum logic [1:0] {
        PHASE_BEFORE = 2'd0,
        PHASE_MOVING = 2'd1,
        PHASE_AFTER  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        REG_START    = 2'd0,
        REG_END      = 2'd1,
        REG_DURATION = 2'd2
    } reg_index_t;

    // multiplier chain result handed to the divider chain
    typedef struct packed {
        phase_t      phase;
        logic        wneg;
        logic [32:0] pmag;
        logic [63:0] pv;
        logic [64:0] pa;
    } poly_out_t;

    // signed 32-bit saturation of a sign and magnitude
    function automatic logic [31:0] sat32(input logic neg, input logic ovf,
                                          input logic [32:0] mag);
        logic [32:0] negmag;
        logic [31:0] res;
        negmag = ~mag + 33'd1;
        if (!neg) begin
            if (ovf || mag > 33'h07FFFFFFF)
                res = 32'h7FFFFFFF;
            else
                res = mag[31:0];
        end
        else begin
            if (ovf || mag > 33'h080000000)
                res = 32'h80000000;
            else
                res = negmag[31:0];
        end
        return res;
    endfunction

endpackage

[src/qtg_div.sv]
// qtg_div: pipelined restoring divider, one quotient bit per stage,
// with a sideband that travels alongside; uses qtg_pkg
module qtg_div #(
    parameter int QW = 32,
    parameter int DW = 31,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_low,
    input  logic [PW-1:0] in_side,
    input  logic [DW-1:0] divisor,
    output logic          out_valid,
    output logic [QW-1:0] out_quot,
    output logic [PW-1:0] out_side
);
    import qtg_pkg::*;

    logic [QW-1:0] vld_reg;
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [PW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          vld_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [PW-1:0] side_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] low_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_rem;
            assign low_in  = in_low;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb
        begin
            trial    = {rem_in, low_in[QW-1]};
            diff     = trial - {1'b0, divisor};
            ge       = (trial >= {1'b0, divisor});
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            low_next = {low_in[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            low_reg[k]  <= low_next;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quot  = low_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

[src/qtg_poly.sv]
// qtg_poly: four-stage multiplier chain from normalized time to the
// position offset and the velocity and acceleration dividends; uses qtg_pkg
module qtg_poly (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [30:0]        s,
    input  qtg_pkg::phase_t    in_phase,
    input  logic [32:0]        dmag,
    output logic               out_valid,
    output qtg_pkg::poly_out_t out_data
);
    import qtg_pkg::*;

    logic [3:0] vld_reg;

    // stage 1 registers
    logic [30:0] s1_s_reg, s1_s2_reg, s1_wmag_reg;
    logic [28:0] s1_su_reg;
    logic        s1_wneg_reg;
    phase_t      s1_phase_reg;
    // stage 2 registers
    logic [30:0] s2_s3_reg;
    logic [34:0] s2_poly_reg;
    logic [26:0] s2_sq_reg;
    logic [28:0] s2_sw_reg;
    logic        s2_wneg_reg;
    phase_t      s2_phase_reg;
    // stage 3 registers
    logic [30:0] s3_f_reg, s3_g_reg;
    logic [31:0] s3_h_reg;
    logic        s3_wneg_reg;
    phase_t      s3_phase_reg;
    // stage 4 registers
    poly_out_t   s4_reg;

    logic [61:0] ss_prod, su_prod;
    logic [30:0] u;
    logic [31:0] s_dbl;
    logic        wneg_next;
    logic [30:0] wmag_next;
    logic [61:0] s3_prod;
    logic [57:0] sq_prod;
    logic [59:0] sw_prod;
    logic [35:0] poly_next;
    logic [65:0] f_prod;
    logic [35:0] g_next;
    logic [35:0] h_next;
    logic [63:0] p_prod;

    // stage 1: s^2, s(1-s), |1-2s|
    always_comb
    begin
        u         = 31'h40000000 - s;
        ss_prod   = {31'd0, s} * {31'd0, s};
        su_prod   = {31'd0, s} * {31'd0, u};
        s_dbl     = {s, 1'b0};
        wneg_next = (s_dbl > 32'h40000000);
        wmag_next = wneg_next ? 31'(s_dbl - 32'h40000000) : 31'(32'h40000000 - s_dbl);
    end

    // stage 2: s^3, blend polynomial, squared and skewed rate terms
    always_comb
    begin
        s3_prod   = {31'd0, s1_s2_reg} * {31'd0, s1_s_reg};
        poly_next = (36'd10 << 30) + 36'd6 * {5'd0, s1_s2_reg} - 36'd15 * {5'd0, s1_s_reg};
        sq_prod   = {29'd0, s1_su_reg} * {29'd0, s1_su_reg};
        sw_prod   = {31'd0, s1_su_reg} * {29'd0, s1_wmag_reg};
    end

    // stage 3: position fraction and scaled rate terms
    always_comb
    begin
        f_prod = {35'd0, s2_s3_reg} * {31'd0, s2_poly_reg};
        g_next = 36'd30 * {9'd0, s2_sq_reg};
        h_next = 36'd15 * {7'd0, s2_sw_reg};
    end

    assign p_prod = {31'd0, dmag} * {33'd0, s3_f_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        s1_s_reg     <= s;
        s1_s2_reg    <= ss_prod[60:30];
        s1_su_reg    <= su_prod[58:30];
        s1_wneg_reg  <= wneg_next;
        s1_wmag_reg  <= wmag_next;
        s1_phase_reg <= in_phase;

        s2_s3_reg    <= s3_prod[60:30];
        s2_poly_reg  <= poly_next[34:0];
        s2_sq_reg    <= sq_prod[56:30];
        s2_sw_reg    <= sw_prod[58:30];
        s2_wneg_reg  <= s1_wneg_reg;
        s2_phase_reg <= s1_phase_reg;

        s3_f_reg     <= f_prod[60:30];
        s3_g_reg     <= g_next[30:0];
        s3_h_reg     <= h_next[31:0];
        s3_wneg_reg  <= s2_wneg_reg;
        s3_phase_reg <= s2_phase_reg;

        s4_reg.phase <= s3_phase_reg;
        s4_reg.wneg  <= s3_wneg_reg;
        s4_reg.pmag  <= p_prod[62:30];
        s4_reg.pv    <= {31'd0, dmag} * {33'd0, s3_g_reg};
        s4_reg.pa    <= {32'd0, dmag} * {33'd0, s3_h_reg};
    end

    assign out_valid = vld_reg[3];
    assign out_data  = s4_reg;

endmodule

[src/quintic_trajectory_generator.sv]
// quintic_trajectory_generator: top level of the minimum-jerk trajectory
// pipeline; uses qtg_pkg, qtg_div and qtg_poly
//
//   channel   handshake            payload
//   config    cfg_write            cfg_index, cfg_data
//   sample    start / busy         time_now
//   result    done (strobe)        position, velocity, acceleration, phase
//
// One sample enters every cycle; busy is always low. Each result passes
// the input register, the normalized-time divider (31 bits), the multiplier
// chain, velocity (32) and acceleration (59 + 33) dividers, output register.
// Reset clears the pipeline valid bits and loads the default registers.
// The receiver cannot stall, so nothing ever waits inside the pipeline.
module quintic_trajectory_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] time_now,
    output logic        done,
    output logic [31:0] position,
    output logic [31:0] velocity,
    output logic [31:0] acceleration,
    output logic [1:0]  phase
);
    import qtg_pkg::*;

    localparam int V_SIDE_W = 2 + 1 + 32 + 65 + 1;
    localparam int A_SIDE_W = 2 + 1 + 32 + 32 + 1 + 1;

    // configuration registers
    logic [31:0] start_reg, end_reg;
    logic [30:0] dur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_reg <= '0;
            end_reg   <= '0;
            dur_reg   <= 31'd65536;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                REG_START:    start_reg <= cfg_data;
                REG_END:      end_reg   <= cfg_data;
                REG_DURATION: dur_reg   <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // travel distance as sign and magnitude
    logic [32:0] diff, dmag;
    logic        dneg;
    assign diff = {end_reg[31], end_reg} - {start_reg[31], start_reg};
    assign dneg = diff[32];
    assign dmag = dneg ? (~diff + 33'd1) : diff;

    // input register: classify the sample
    logic        in_valid_reg;
    logic [30:0] in_t_reg;
    phase_t      in_phase_reg;
    phase_t      phase_next;

    always_comb
    begin
        if (time_now[31])
            phase_next = PHASE_BEFORE;
        else if (dur_reg == '0 || time_now[30:0] > dur_reg)
            phase_next = PHASE_AFTER;
        else
            phase_next = PHASE_MOVING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        in_phase_reg <= phase_next;
        in_t_reg     <= (phase_next == PHASE_MOVING) ? time_now[30:0] : '0;
    end

    assign busy = 1'b0;

    // normalized time s = t / T in Q1.30
    logic        sd_valid;
    logic [30:0] sd_quot;
    logic [1:0]  sd_side;

    qtg_div #(.QW(S_QBITS), .DW(DUR_W), .PW(2)) u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_rem   ({1'b0, in_t_reg[30:1]}),
        .in_low   ({in_t_reg[0], 30'd0}),
        .in_side  (in_phase_reg),
        .divisor  (dur_reg),
        .out_valid(sd_valid),
        .out_quot (sd_quot),
        .out_side (sd_side)
    );

    // multiplier chain
    logic      pl_valid;
    poly_out_t pl_data;

    qtg_poly u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sd_valid),
        .s        (sd_quot),
        .in_phase (phase_t'(sd_side)),
        .dmag     (dmag),
        .out_valid(pl_valid),
        .out_data (pl_data)
    );

    // position and velocity divider entry
    logic [32:0] pos_sum;
    logic [17:0] v_top;
    logic        v_ovf;
    assign pos_sum = dneg ? ({start_reg[31], start_reg} - pl_data.pmag)
                          : ({start_reg[31], start_reg} + pl_data.pmag);
    assign v_top   = pl_data.pv[63:46];
    assign v_ovf   = ({13'd0, v_top} >= dur_reg);

    logic                vd_valid;
    logic [31:0]         vd_quot;
    logic [V_SIDE_W-1:0] vd_side;

    qtg_div #(.QW(V_QBITS), .DW(DUR_W), .PW(V_SIDE_W)) u_vdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pl_valid),
        .in_rem   (v_ovf ? 31'd0 : {13'd0, v_top}),
        .in_low   (pl_data.pv[45:14]),
        .in_side  ({pl_data.phase, pl_data.wneg, pos_sum[31:0], pl_data.pa, v_ovf}),
        .divisor  (dur_reg),
        .out_valid(vd_valid),
        .out_quot (vd_quot),
        .out_side (vd_side)
    );

    // acceleration, first division by T
    logic [64:0] a_pa;
    logic [5:0]  a1_top;
    logic        a1_ovf;
    assign a_pa   = vd_side[65:1];
    assign a1_top = a_pa[64:59];
    assign a1_ovf = ({25'd0, a1_top} >= dur_reg);

    logic                a1_valid;
    logic [58:0]         a1_quot;
    logic [A_SIDE_W-1:0] a1_side;

    qtg_div #(.QW(A1_QBITS), .DW(DUR_W), .PW(A_SIDE_W)) u_a1div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vd_valid),
        .in_rem   (a1_ovf ? 31'd0 : {25'd0, a1_top}),
        .in_low   (a_pa[58:0]),
        .in_side  ({vd_side[100:66], vd_quot, vd_side[0], a1_ovf}),
        .divisor  (dur_reg),
        .out_valid(a1_valid),
        .out_quot (a1_quot),
        .out_side (a1_side)
    );

    // acceleration, second division: 16 q / T
    logic [29:0] a2_top;
    logic        a2_ovf;
    assign a2_top = a1_quot[58:29];
    assign a2_ovf = ({1'b0, a2_top} >= dur_reg);

    logic                a2_valid;
    logic [32:0]         a2_quot;
    logic [A_SIDE_W-1:0] a2_side;

    qtg_div #(.QW(A2_QBITS), .DW(DUR_W), .PW(A_SIDE_W)) u_a2div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (a1_valid),
        .in_rem   (a2_ovf ? 31'd0 : {1'b0, a2_top}),
        .in_low   ({a1_quot[28:0], 4'd0}),
        .in_side  ({a1_side[A_SIDE_W-1:1], a1_side[0] | a2_ovf}),
        .divisor  (dur_reg),
        .out_valid(a2_valid),
        .out_quot (a2_quot),
        .out_side (a2_side)
    );

    // unpack sideband
    phase_t      o_phase;
    logic        o_wneg, o_vovf, o_aovf;
    logic [31:0] o_pos, o_vq;
    assign o_phase = phase_t'(a2_side[68:67]);
    assign o_wneg  = a2_side[66];
    assign o_pos   = a2_side[65:34];
    assign o_vq    = a2_side[33:2];
    assign o_vovf  = a2_side[1];
    assign o_aovf  = a2_side[0];

    // output register
    logic        done_reg;
    logic [31:0] position_reg, velocity_reg, acceleration_reg;
    logic [1:0]  phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= a2_valid;
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= o_phase;
        case (o_phase)
            PHASE_MOVING: begin
                position_reg     <= o_pos;
                velocity_reg     <= sat32(dneg, o_vovf, {1'b0, o_vq});
                acceleration_reg <= sat32(dneg ^ o_wneg, o_aovf, a2_quot);
            end
            PHASE_BEFORE: begin
                position_reg     <= start_reg;
                velocity_reg     <= '0;
                acceleration_reg <= '0;
            end
            default: begin
                position_reg     <= end_reg;
                velocity_reg     <= '0;
                acceleration_reg <= '0;
            end
        endcase
    end

    assign done         = done_reg;
    assign position     = position_reg;
    assign velocity     = velocity_reg;
    assign acceleration = acceleration_reg;
    assign phase        = phase_reg;

endmodule

[src/qtg_checker.sv]
// qtg_checker: port-level assertions for the trajectory generator and the
// bind that attaches them; uses qtg_pkg
module qtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] velocity,
    input logic [31:0] acceleration,
    input logic [1:0]  phase
);
    import qtg_pkg::*;

    // every result beat traces back to an accepted sample
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without matching sample");

    // the pipeline takes a sample in every cycle
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // outside the motion both rates are zero
    a_rest_rates: assert property (@(posedge clk) disable iff (!rst_n)
        (done && phase != PHASE_MOVING) |-> (velocity == '0 && acceleration == '0))
        else $error("nonzero rate outside the motion");

endmodule

bind quintic_trajectory_generator qtg_checker u_qtg_checker (.*);
